// ----- design/pcf_pkg.sv -----
package pcf_pkg;

  // widths fixed by the item and result formats
  localparam int ACTION_W = 2;
  localparam int SLOT_W   = 4;
  localparam int ADDR_W   = 64;
  localparam int BYTE_W   = 8;
  localparam int WORD_W   = 64;
  localparam int WINDOW_W = WORD_W - BYTE_W;
  localparam int COUNT_W  = 5;

  localparam int NUM_REGIONS_DEF = 16;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_START = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_BYTE  = 2'd2;

  // token kinds moving down the cell chain
  localparam logic [1:0] TOK_NONE  = 2'd0;
  localparam logic [1:0] TOK_WRITE = 2'd1;
  localparam logic [1:0] TOK_CAND  = 2'd2;

  // configuration reset values
  localparam logic [WORD_W-1:0] PTR_LOW_RST  = 64'h0000_0000_0001_0000;
  localparam logic [WORD_W-1:0] PTR_HIGH_RST = 64'h0000_7FFF_FFFF_FFFF;

  // the lag from window end to word start (one less than the bytes in a word)
  localparam logic [ADDR_W-1:0] WORD_LAG = 64'd7;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [SLOT_W-1:0]   slot;
    logic [ADDR_W-1:0]   base_address;
    logic [ADDR_W-1:0]   region_length;
    logic [BYTE_W-1:0]   data_byte;
  } pcf_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] pointer_value;
    logic [ADDR_W-1:0] location;
  } pcf_result_t;

  // write token: a = base, b = base + size
  // candidate token: a = word, b = location, hit = found in some region
  typedef struct packed {
    logic [1:0]        kind;
    logic [SLOT_W-1:0] slot;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic              hit;
  } pcf_tok_t;

endpackage

// ----- design/pcf_front.sv -----
module pcf_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic                advance,
  input  pcf_pkg::pcf_item_t  item,
  input  logic                aligned_only,
  input  logic [63:0]         pointer_low,
  input  logic [63:0]         pointer_high,
  output pcf_pkg::pcf_tok_t   tok
);
  import pcf_pkg::*;

  logic [WINDOW_W-1:0] window;
  logic [WINDOW_W-1:0] window_next;
  logic [ADDR_W-1:0]   seen;
  logic [ADDR_W-1:0]   seen_next;
  logic [ADDR_W-1:0]   wstart;
  logic [ADDR_W-1:0]   wstart_next;
  logic [WORD_W-1:0]   word;
  logic                tested;
  pcf_tok_t            tok_next;

  assign word = {item.data_byte, window};

  always_comb begin
    window_next = window;
    seen_next   = seen;
    wstart_next = wstart;
    tested      = 1'b0;
    tok_next    = '0;
    tok_next.kind = TOK_NONE;
    tok_next.slot = item.slot;
    if (take) begin
      case (item.action)
        ACT_WRITE: begin
          tok_next.kind = TOK_WRITE;
          tok_next.a    = item.base_address;
          tok_next.b    = item.base_address + item.region_length;
        end
        ACT_START: begin
          window_next = '0;
          seen_next   = '0;
          wstart_next = item.base_address - WORD_LAG;
        end
        ACT_BYTE: begin
          window_next = word[WORD_W-1:BYTE_W];
          seen_next   = seen + 64'd1;
          wstart_next = wstart + 64'd1;
          // full word present, alignment ok, inside the value bounds
          tested = (seen_next[ADDR_W-1:3] != '0) &&
                   (!aligned_only || seen_next[2:0] == 3'd0) &&
                   (word >= pointer_low) && (word <= pointer_high);
          if (tested) begin
            tok_next.kind = TOK_CAND;
            tok_next.a    = word;
            tok_next.b    = wstart;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window   <= '0;
      seen     <= '0;
      wstart   <= '0 - WORD_LAG;
      tok.kind <= TOK_NONE;
    end else if (advance) begin
      window <= window_next;
      seen   <= seen_next;
      wstart <= wstart_next;
      tok    <= tok_next;
    end
  end

endmodule

// ----- design/pcf_cell.sv -----
module pcf_cell #(
  parameter int INDEX = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic              active,
  input  pcf_pkg::pcf_tok_t tok_in,
  output pcf_pkg::pcf_tok_t tok_out
);
  import pcf_pkg::*;

  logic [WORD_W-1:0] base;
  logic [WORD_W-1:0] limit;
  logic              match;
  pcf_tok_t          tok_next;

  // region end is kept precomputed, so the check is two compares
  assign match = (tok_in.a >= base) && (tok_in.a < limit);

  always_comb begin
    tok_next     = tok_in;
    tok_next.hit = tok_in.hit ||
                   (active && tok_in.kind == TOK_CAND && match);
  end

  always_ff @(posedge clk) begin
    if (advance && tok_in.kind == TOK_WRITE && 32'(tok_in.slot) == INDEX) begin
      base  <= tok_in.a;
      limit <= tok_in.b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.kind <= TOK_NONE;
    end else if (advance) begin
      tok_out <= tok_next;
    end
  end

endmodule

// ----- design/pointer_candidate_filter.sv -----
// pointer candidate filter
//
// item channel (item_valid / item_stall / item): action 0 loads a region
// slot with base and size, action 1 opens a byte stream at base_address,
// action 2 delivers one stream byte. every byte from the eighth of a stream
// on closes a little-endian 64-bit word; a word inside the pointer bounds
// and inside any active region (at offsets 8n if aligned_only) comes out on
// the result channel (result_valid / result_stall / result) with its start
// address. configuration sits behind an apb-style port, one 64-bit register
// per 8-byte slot: aligned_only, pointer_low, pointer_high, region_count.
//
// one item is taken every cycle unless item_stall is high. a candidate
// passes the front stage, then a chain of NUM_REGIONS region cells, one
// cell per chain move, then the output register before it is a result.
// region writes travel down the same chain, so they take effect in item
// order. a stalled result freezes the whole chain and raises item_stall.
// reset clears the stream state and the chain and loads the configuration
// reset values; region slots hold nothing defined until written.
module pointer_candidate_filter #(
  parameter int NUM_REGIONS = pcf_pkg::NUM_REGIONS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  // item channel
  input  logic                item_valid,
  output logic                item_stall,
  input  pcf_pkg::pcf_item_t  item,
  // result channel
  output logic                result_valid,
  input  logic                result_stall,
  output pcf_pkg::pcf_result_t result,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready
);
  import pcf_pkg::*;

  // register indexes
  localparam logic [1:0] REG_ALIGNED = 2'd0;
  localparam logic [1:0] REG_LOW     = 2'd1;
  localparam logic [1:0] REG_HIGH    = 2'd2;
  localparam logic [1:0] REG_COUNT   = 2'd3;

  logic               aligned_only;
  logic [WORD_W-1:0]  pointer_low;
  logic [WORD_W-1:0]  pointer_high;
  logic [COUNT_W-1:0] region_count;

  logic               advance;
  logic               take;
  logic               cfg_write;
  logic [1:0]         reg_index;
  pcf_tok_t           chain [0:NUM_REGIONS];
  logic [NUM_REGIONS-1:0] active;

  // ---------------------------------------------------------------------
  // configuration registers, written in the access phase
  // ---------------------------------------------------------------------
  assign pready    = 1'b1;
  assign reg_index = paddr[4:3];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      aligned_only <= 1'b0;
      pointer_low  <= PTR_LOW_RST;
      pointer_high <= PTR_HIGH_RST;
      region_count <= '0;
    end else if (cfg_write) begin
      unique case (reg_index)
        REG_ALIGNED: aligned_only <= pwdata[0];
        REG_LOW:     pointer_low  <= pwdata;
        REG_HIGH:    pointer_high <= pwdata;
        REG_COUNT:   region_count <= pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_ALIGNED: prdata = {63'd0, aligned_only};
      REG_LOW:     prdata = pointer_low;
      REG_HIGH:    prdata = pointer_high;
      REG_COUNT:   prdata = {{(64-COUNT_W){1'b0}}, region_count};
      default:     prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // flow control: the chain moves unless a result waits on a stall
  // ---------------------------------------------------------------------
  assign advance    = !(result_valid && result_stall);
  assign item_stall = !advance;
  assign take       = item_valid && advance;

  // stream tracking and bounds test, first chain stage
  pcf_front u_front (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .advance      (advance),
    .item         (item),
    .aligned_only (aligned_only),
    .pointer_low  (pointer_low),
    .pointer_high (pointer_high),
    .tok          (chain[0])
  );

  // one cell per region slot; a slot counts only below region_count
  for (genvar i = 0; i < NUM_REGIONS; i++) begin : g_cell
    assign active[i] = 32'(region_count) > i;

    pcf_cell #(
      .INDEX (i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .active  (active[i]),
      .tok_in  (chain[i]),
      .tok_out (chain[i+1])
    );
  end

  // ---------------------------------------------------------------------
  // output register: a candidate that hit some region becomes a transfer
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= chain[NUM_REGIONS].kind == TOK_CAND && chain[NUM_REGIONS].hit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.pointer_value <= chain[NUM_REGIONS].a;
      result.location      <= chain[NUM_REGIONS].b;
    end
  end

endmodule

// ----- design/pcf_checker.sv -----
module pcf_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 item_stall,
  input logic                 result_valid,
  input logic                 result_stall,
  input pcf_pkg::pcf_result_t result
);
  import pcf_pkg::*;

  // a held result keeps its payload
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // the item side stalls exactly when a result is held back
  a_stall_link: assert property (@(posedge clk) disable iff (rst)
    item_stall == (result_valid && result_stall))
    else $error("item stall does not follow result stall");

  // reset empties the output register
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

  // a new result only appears through a move of the chain
  a_rise_on_move: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(!item_stall))
    else $error("result appeared while the chain was frozen");

endmodule

bind pointer_candidate_filter pcf_checker u_checker (.*);

// ----- sim/testbench.sv -----
module testbench;
  import pcf_pkg::*;

  localparam int REGIONS = NUM_REGIONS_DEF;
  // settle wait, sized with margin from the pipeline depth: chain of region cells plus in/out registers
  localparam int SETTLE_CYCLES = 3 * (REGIONS + 2);
  localparam int CYCLE_LIMIT = 200000;

  // action code the block ignores
  localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;

  // register byte addresses (64-bit registers, 8 bytes apart)
  localparam logic [4:0] REG_ALIGNED = 5'd0;
  localparam logic [4:0] REG_LOW     = 5'd8;
  localparam logic [4:0] REG_HIGH    = 5'd16;
  localparam logic [4:0] REG_COUNT   = 5'd24;

  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  // tracks the block state and the pointer hits it owes us
  class pointer_tracker;
    logic [63:0] region_base [REGIONS];
    logic [63:0] region_size [REGIONS];
    logic [WINDOW_W-1:0] window;
    logic [63:0] seen;
    logic [63:0] start;
    logic aligned;
    logic [63:0] low;
    logic [63:0] high;
    logic [COUNT_W-1:0] count;
    pcf_result_t hits_due[$];
    int errors;

    function new();
      window = '0;
      seen = '0;
      start = '0;
      aligned = 1'b0;
      low = PTR_LOW_RST;
      high = PTR_HIGH_RST;
      count = '0;
      errors = 0;
      for (int i = 0; i < REGIONS; i++) begin
        region_base[i] = '0;
        region_size[i] = '0;
      end
    endfunction

    function void set_reg(logic [4:0] addr, logic [63:0] value);
      case (addr)
        REG_ALIGNED: aligned = value[0];
        REG_LOW:     low = value;
        REG_HIGH:    high = value;
        REG_COUNT:   count = value[COUNT_W-1:0];
        default: ;
      endcase
    endfunction

    function bit in_region(logic [63:0] v);
      int n;
      logic [63:0] lim;
      n = (count > REGIONS) ? REGIONS : count;
      for (int i = 0; i < n; i++) begin
        lim = region_base[i] + region_size[i];
        if (v >= region_base[i] && v < lim) return 1'b1;
      end
      return 1'b0;
    endfunction

    // update state for one accepted item, queue a hit if the word passes
    function void take_item(pcf_item_t it);
      logic [63:0] word;
      logic [63:0] offset;
      pcf_result_t hit;
      case (it.action)
        ACT_WRITE: begin
          region_base[it.slot] = it.base_address;
          region_size[it.slot] = it.region_length;
        end
        ACT_START: begin
          start = it.base_address;
          seen = '0;
          window = '0;
        end
        ACT_BYTE: begin
          word = {it.data_byte, window};
          seen = seen + 64'd1;
          window = word[63:8];
          if (seen < 64'd8) return;
          offset = seen - 64'd8;
          if (aligned && offset[2:0] != 3'd0) return;
          if (word < low || word > high) return;
          if (!in_region(word)) return;
          hit.pointer_value = word;
          hit.location = start + offset;
          hits_due = {hits_due, hit};
        end
        default: ;
      endcase
    endfunction

    function void match_hit(pcf_result_t got);
      pcf_result_t want;
      if (hits_due.size() == 0) begin
        $display("%0t: unexpected result pointer_value=%h location=%h",
                 $time, got.pointer_value, got.location);
        errors++;
        return;
      end
      want = hits_due.pop_front();
      if (got.pointer_value !== want.pointer_value) begin
        $display("%0t: pointer_value mismatch expected=%h actual=%h",
                 $time, want.pointer_value, got.pointer_value);
        errors++;
      end
      if (got.location !== want.location) begin
        $display("%0t: location mismatch expected=%h actual=%h",
                 $time, want.location, got.location);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  pcf_item_t item_bus = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  pcf_result_t result_bus;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  pointer_tracker sb = new();

  // idling knobs, percent per cycle
  int send_pct = 0;
  int stall_pct = 0;
  int send_quiet = 0;
  int stall_quiet = 0;
  int cycles = 0;

  pointer_candidate_filter DUT (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item_bus),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result_bus),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver stall pattern, with occasional quiet stretches
  always @(posedge clk) begin
    if (stall_quiet != 0) begin
      stall_quiet <= stall_quiet - 1;
      result_stall <= 1'b0;
    end else begin
      if ($urandom_range(99) < 3) stall_quiet <= $urandom_range(24, 8);
      result_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // result monitor: a transfer happens when valid is high and stall is low
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.match_hit(result_bus);
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // item with every field random, so unused fields still toggle
  function automatic pcf_item_t noise_item(logic [ACTION_W-1:0] act);
    pcf_item_t it;
    it.action = act;
    it.slot = SLOT_W'($urandom());
    it.base_address = rand64();
    it.region_length = rand64();
    it.data_byte = BYTE_W'($urandom());
    return it;
  endfunction

  // hold the item until a transfer, then let the tracker see it
  task automatic send_item(pcf_item_t it);
    if (send_quiet != 0) begin
      send_quiet--;
    end else begin
      if ($urandom_range(99) < 3) send_quiet = $urandom_range(24, 8);
      while ($urandom_range(99) < send_pct) begin
        item_valid <= 1'b0;
        @(posedge clk);
      end
    end
    item_valid <= 1'b1;
    item_bus <= it;
    do @(posedge clk); while (item_stall);
    sb.take_item(it);
  endtask

  task automatic send_region(int slot, logic [63:0] base, logic [63:0] size);
    pcf_item_t it;
    it = noise_item(ACT_WRITE);
    it.slot = SLOT_W'(slot);
    it.base_address = base;
    it.region_length = size;
    send_item(it);
  endtask

  // mostly small regions in user space, some odd ones (empty, huge, wrapping)
  task automatic send_random_region(int slot);
    int r;
    logic [63:0] base;
    logic [63:0] size;
    r = $urandom_range(99);
    if (r < 80) begin
      base = 64'h1_0000 + rand64() % 64'h7FFF_FFFE_E000;
      size = 64'($urandom_range(4096, 1));
    end else if (r < 88) begin
      base = rand64();
      size = rand64();
    end else if (r < 94) begin
      base = rand64();
      size = '0;
    end else begin
      base = 64'hFFFF_FFFF_FFFF_F000 | 64'($urandom_range(4095));
      size = 64'($urandom_range(8192, 1));
    end
    send_region(slot, base, size);
  endtask

  task automatic send_start(logic [63:0] addr);
    pcf_item_t it;
    it = noise_item(ACT_START);
    it.base_address = addr;
    send_item(it);
  endtask

  // eight bytes, least significant first, so the word lands on one test
  task automatic send_word(logic [63:0] w);
    pcf_item_t it;
    for (int k = 0; k < 8; k++) begin
      it = noise_item(ACT_BYTE);
      it.data_byte = w[8*k +: 8];
      send_item(it);
    end
  endtask

  // usually a pointer into an active region, otherwise plain noise
  function automatic logic [63:0] pick_word();
    int n;
    int s;
    logic [63:0] w;
    n = (sb.count > REGIONS) ? REGIONS : sb.count;
    w = rand64();
    if (n != 0 && $urandom_range(99) < 75) begin
      s = $urandom_range(n - 1, 0);
      if (sb.region_size[s] != 0) w = sb.region_base[s] + rand64() % sb.region_size[s];
    end
    return w;
  endfunction

  // stop sending and let every owed hit come out, plus a margin sized from the chain depth
  task automatic settle();
    item_valid <= 1'b0;
    @(posedge clk);
    while (sb.hits_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(logic [4:0] addr, logic [63:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_reg(addr, value);
  endtask

  task automatic set_config(logic aligned, logic [63:0] low, logic [63:0] high,
                            logic [COUNT_W-1:0] count);
    reg_write(REG_ALIGNED, {63'd0, aligned});
    reg_write(REG_LOW, low);
    reg_write(REG_HIGH, high);
    reg_write(REG_COUNT, {59'd0, count});
  endtask

  // one random phase: region rewrites, new streams, spare actions, words
  task automatic run_phase(logic aligned, logic [63:0] low, logic [63:0] high,
                           logic [COUNT_W-1:0] count, int s_pct, int r_pct,
                           int n_items, bit pause);
    int sent;
    int r;
    bit paused;
    pcf_item_t it;
    settle();
    set_config(aligned, low, high, count);
    send_pct = s_pct;
    stall_pct = r_pct;
    sent = 0;
    paused = 0;
    while (sent < n_items) begin
      // with pause set, halfway through, hold off the sender until every owed hit has come out
      if (pause && !paused && sent >= n_items / 2) begin
        paused = 1;
        item_valid <= 1'b0;
        @(posedge clk);
        while (sb.hits_due.size() != 0) @(posedge clk);
      end
      r = $urandom_range(99);
      if (r < 4) begin
        send_random_region($urandom_range(REGIONS - 1));
        sent++;
      end else if (r < 8) begin
        if ($urandom_range(99) < 20) send_start(64'hFFFF_FFFF_FFFF_FFF0 | $urandom_range(15));
        else send_start(rand64());
        sent++;
      end else if (r < 10) begin
        // ignored by the block, not counted
        it = noise_item(ACT_SPARE);
        send_item(it);
      end else begin
        send_word(pick_word());
        sent += 8;
      end
    end
  endtask

  initial begin
    pcf_item_t it;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // fill every slot while region_count is still zero
    for (int s = 0; s < REGIONS; s++) send_random_region(s);
    settle();
    set_config(1'b0, '0, ALL_ONES, 5'd16);

    // directed: region edges, spare action, bytes before any stream start,
    // word at the top of the address space with a near-top stream start
    send_region(0, 64'h1000_0000, 64'h100);
    send_region(1, 64'hFFFF_FFFF_FFFF_FF00, 64'h100);  // end wraps to zero
    send_region(2, 64'hFFFF_FFFF_FFFF_FFF0, 64'hF);    // ends at all ones
    send_region(3, '0, '0);                            // empty region
    it = noise_item(ACT_SPARE);
    send_item(it);
    send_word(64'h0000_0000_1000_00FF);                // last byte of slot 0
    send_start(64'hFFFF_FFFF_FFFF_FFFC);
    send_word(64'hFFFF_FFFF_FFFF_FFFE);
    send_word(64'h0000_0000_0000_0000);

    // random phases across settings and idling mixes
    run_phase(1'b0, '0, ALL_ONES, 5'd16, 0, 0, 80, 0);
    run_phase(1'b1, PTR_LOW_RST, PTR_HIGH_RST, 5'd31, 49, 0, 80, 0);  // count above table
    run_phase(1'b1, PTR_LOW_RST, PTR_HIGH_RST, 5'd9, 0, 49, 80, 1);
    run_phase(1'b0, PTR_LOW_RST, PTR_HIGH_RST, 5'd16, 29, 29, 80, 0);
    run_phase(1'b1, ALL_ONES, '0, 5'd1, 29, 29, 40, 0);                 // empty range
    run_phase(1'b0, '0, ALL_ONES, 5'd0, 49, 49, 40, 0);                 // no regions

    settle();
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
